// File: rtl/htd_pkg.sv
// Shared constants, codes and types of the Huffman table decoder.
package htd_pkg;

  // Code table geometry
  localparam int TABLE_DEPTH  = 256;
  localparam int MAX_CODE_LEN = 16;
  localparam int ADDR_W       = $clog2(TABLE_DEPTH);
  localparam int LIM_W        = $clog2(TABLE_DEPTH + 1);

  // Field widths
  localparam int IDX_W  = 8;
  localparam int CODE_W = 16;
  localparam int LEN_W  = 5;
  localparam int SYM_W  = 8;
  localparam int BYTE_W = 8;

  // Bit buffer, left aligned at its top bit
  localparam int BUF_BITS = 24;
  localparam int CNT_W    = $clog2(BUF_BITS + 1);

  // Symbols emitted per data byte at most
  localparam int MAX_RESULTS = 16;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Configuration port
  localparam int ENTRY_CNT_W = 9;
  localparam int PAD_W       = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 9;

  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_BITS    = 1'd1;

  // Input action codes
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_DECODE = 1'b1;

  // One classified transaction held in the queue
  typedef struct packed {
    logic              is_load;
    logic [ADDR_W-1:0] index;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic [SYM_W-1:0]  sym;
    logic [BYTE_W-1:0] data;
  } q_entry_t;

endpackage

// File: rtl/htd_if.sv
// Valid/ready channel interfaces for input items and decoded symbols.
interface htd_in_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [htd_pkg::IDX_W-1:0]    entry_index;
  logic [htd_pkg::CODE_W-1:0]   code_bits;
  logic [htd_pkg::LEN_W-1:0]    code_length;
  logic [htd_pkg::SYM_W-1:0]    entry_symbol;
  logic [htd_pkg::BYTE_W-1:0]   data_byte;

  modport source (
    output valid, action, entry_index, code_bits, code_length, entry_symbol, data_byte,
    input  ready
  );
  modport sink (
    input  valid, action, entry_index, code_bits, code_length, entry_symbol, data_byte,
    output ready
  );
endinterface

interface htd_out_if;
  logic                       valid;
  logic                       ready;
  logic [htd_pkg::SYM_W-1:0]  symbol;
  logic                       last;

  modport source (
    output valid, symbol, last,
    input  ready
  );
  modport sink (
    input  valid, symbol, last,
    output ready
  );
endinterface

// File: rtl/htd_front.sv
// Front end: takes input transactions, classifies them and hands them to the queue.
module htd_front (
  input  logic              clk,
  input  logic              rst_n,
  htd_in_if.sink            in_chan,
  output logic              push_valid,
  input  logic              push_ready,
  output htd_pkg::q_entry_t push_data
);

  logic              stage_valid_r, stage_valid_nxt;
  htd_pkg::q_entry_t stage_r, stage_nxt;
  logic              accept;
  logic              keep;

  // Stage frees up whenever the queue takes its content
  assign in_chan.ready = !stage_valid_r || push_ready;
  assign accept        = in_chan.valid && in_chan.ready;

  // Loads aimed past the table are dropped here
  assign keep = (in_chan.action == htd_pkg::ACT_DECODE) ||
                (32'(in_chan.entry_index) < htd_pkg::TABLE_DEPTH);

  always_comb begin
    stage_nxt.is_load = (in_chan.action == htd_pkg::ACT_LOAD);
    stage_nxt.index   = htd_pkg::ADDR_W'(in_chan.entry_index);
    stage_nxt.code    = in_chan.code_bits;
    stage_nxt.len     = in_chan.code_length;
    stage_nxt.sym     = in_chan.entry_symbol;
    stage_nxt.data    = in_chan.data_byte;
  end

  assign stage_valid_nxt = accept ? keep : (stage_valid_r && !push_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_r <= stage_nxt;
    end
  end

  assign push_valid = stage_valid_r;
  assign push_data  = stage_r;

endmodule

// File: rtl/htd_queue.sv
// Short queue that decouples the front end from the decode engine.
module htd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  htd_pkg::q_entry_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output htd_pkg::q_entry_t pop_data
);

  htd_pkg::q_entry_t               slot_r [htd_pkg::QUEUE_DEPTH];
  logic [htd_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [htd_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [htd_pkg::QPTR_W:0]        fill_r, fill_nxt;
  logic                            do_push, do_pop;

  assign push_ready = (fill_r != (htd_pkg::QPTR_W+1)'(htd_pkg::QUEUE_DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer advance with wrap
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == htd_pkg::QPTR_W'(htd_pkg::QUEUE_DEPTH - 1)) ? '0
                 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == htd_pkg::QPTR_W'(htd_pkg::QUEUE_DEPTH - 1)) ? '0
                 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/htd_back.sv
// Decode engine: code table memory, bit buffer, table scan and symbol output register.
module htd_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              pop_valid,
  output logic                              pop_ready,
  input  htd_pkg::q_entry_t                 pop_data,
  input  logic [htd_pkg::ENTRY_CNT_W-1:0]   entry_count,
  input  logic [htd_pkg::PAD_W-1:0]         pad_bits,
  htd_out_if.source                         out_chan
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_HIT   = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  typedef struct packed {
    logic [htd_pkg::CODE_W-1:0] code;
    logic [htd_pkg::LEN_W-1:0]  len;
    logic [htd_pkg::SYM_W-1:0]  sym;
  } tbl_word_t;

  // Code table
  tbl_word_t                        mem_r [htd_pkg::TABLE_DEPTH];
  logic                             mem_we;
  tbl_word_t                        mem_wdata;
  tbl_word_t                        rd_data_r;

  logic [1:0]                       state_r, state_nxt;
  logic [htd_pkg::BUF_BITS-1:0]     buf_r, buf_nxt;
  logic [htd_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                             first_r, first_nxt;
  logic [htd_pkg::RES_CNT_W-1:0]    n_r, n_nxt;
  logic [htd_pkg::LIM_W-1:0]        issue_r, issue_nxt;
  logic                             rd_vld_r, rd_vld_nxt;
  logic [htd_pkg::SYM_W-1:0]        hit_sym_r, hit_sym_nxt;
  logic [htd_pkg::LEN_W-1:0]        hit_len_r, hit_len_nxt;
  logic [htd_pkg::SYM_W-1:0]        held_r, held_nxt;
  logic                             have_held_r, have_held_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [htd_pkg::SYM_W-1:0]        out_sym_r;
  logic                             out_last_r;

  logic                             push, push_last;
  logic                             out_free;
  logic [htd_pkg::LIM_W-1:0]        limit;
  logic                             issue_more;
  logic [htd_pkg::BUF_BITS-1:0]     byte_al;
  logic [htd_pkg::LEN_W-1:0]        shamt;
  logic [htd_pkg::BUF_BITS-1:0]     code_al, lead_mask;
  logic                             len_ok, hit;

  // Entries searched: configured count, capped at the table size
  assign limit = (32'(entry_count) < htd_pkg::TABLE_DEPTH) ? htd_pkg::LIM_W'(entry_count)
               : htd_pkg::LIM_W'(htd_pkg::TABLE_DEPTH);
  assign issue_more = (issue_r < limit);

  // Compare the entry read last cycle with the leading buffer bits
  assign shamt     = htd_pkg::LEN_W'(htd_pkg::BUF_BITS) - rd_data_r.len;
  assign code_al   = htd_pkg::BUF_BITS'(rd_data_r.code) << shamt;
  assign lead_mask = ~({htd_pkg::BUF_BITS{1'b1}} >> rd_data_r.len);
  assign len_ok    = (rd_data_r.len != '0) &&
                     (32'(rd_data_r.len) <= htd_pkg::MAX_CODE_LEN) &&
                     (htd_pkg::CNT_W'(rd_data_r.len) <= cnt_r);
  assign hit       = rd_vld_r && len_ok && (((buf_r ^ code_al) & lead_mask) == '0);

  // New byte aligned at the top of the buffer
  assign byte_al = htd_pkg::BUF_BITS'(pop_data.data) << (htd_pkg::BUF_BITS - htd_pkg::BYTE_W);

  assign out_free = !out_valid_r || out_chan.ready;

  always_comb begin
    mem_wdata.code = pop_data.code;
    mem_wdata.len  = pop_data.len;
    mem_wdata.sym  = pop_data.sym;
  end

  // Control sequencer
  always_comb begin
    state_nxt     = state_r;
    buf_nxt       = buf_r;
    cnt_nxt       = cnt_r;
    first_nxt     = first_r;
    n_nxt         = n_r;
    issue_nxt     = issue_r;
    rd_vld_nxt    = rd_vld_r;
    hit_sym_nxt   = hit_sym_r;
    hit_len_nxt   = hit_len_r;
    held_nxt      = held_r;
    have_held_nxt = have_held_r;
    mem_we        = 1'b0;
    pop_ready     = 1'b0;
    push          = 1'b0;
    push_last     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          if (pop_data.is_load) begin
            mem_we = 1'b1;
          end else begin
            if (first_r) begin
              buf_nxt   = byte_al << pad_bits;
              cnt_nxt   = htd_pkg::CNT_W'(htd_pkg::BYTE_W) - htd_pkg::CNT_W'(pad_bits);
              first_nxt = 1'b0;
            end else if (cnt_r <= htd_pkg::CNT_W'(htd_pkg::BUF_BITS - htd_pkg::BYTE_W)) begin
              buf_nxt = buf_r | (byte_al >> cnt_r);
              cnt_nxt = cnt_r + htd_pkg::CNT_W'(htd_pkg::BYTE_W);
            end
            n_nxt      = '0;
            issue_nxt  = '0;
            rd_vld_nxt = 1'b0;
            state_nxt  = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          hit_sym_nxt = rd_data_r.sym;
          hit_len_nxt = rd_data_r.len;
          rd_vld_nxt  = 1'b0;
          state_nxt   = ST_HIT;
        end else if (issue_more) begin
          issue_nxt  = issue_r + 1'b1;
          rd_vld_nxt = 1'b1;
        end else begin
          rd_vld_nxt = 1'b0;
          // nothing in flight and nothing left: no entry matches
          if (!rd_vld_r) begin
            state_nxt = have_held_r ? ST_FLUSH : ST_IDLE;
          end
        end
      end
      ST_HIT: begin
        if (!have_held_r || out_free) begin
          push          = have_held_r;
          held_nxt      = hit_sym_r;
          have_held_nxt = 1'b1;
          buf_nxt       = buf_r << hit_len_r;
          cnt_nxt       = cnt_r - htd_pkg::CNT_W'(hit_len_r);
          n_nxt         = n_r + 1'b1;
          issue_nxt     = '0;
          rd_vld_nxt    = 1'b0;
          state_nxt     = (n_r + 1'b1 == htd_pkg::RES_CNT_W'(htd_pkg::MAX_RESULTS))
                        ? ST_FLUSH : ST_SCAN;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          push          = 1'b1;
          push_last     = 1'b1;
          have_held_nxt = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
    endcase
  end

  assign out_valid_nxt = push ? 1'b1 : (out_valid_r && !out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      buf_r       <= '0;
      cnt_r       <= '0;
      first_r     <= 1'b1;
      n_r         <= '0;
      issue_r     <= '0;
      rd_vld_r    <= 1'b0;
      have_held_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      buf_r       <= buf_nxt;
      cnt_r       <= cnt_nxt;
      first_r     <= first_nxt;
      n_r         <= n_nxt;
      issue_r     <= issue_nxt;
      rd_vld_r    <= rd_vld_nxt;
      have_held_r <= have_held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    hit_sym_r <= hit_sym_nxt;
    hit_len_r <= hit_len_nxt;
    held_r    <= held_nxt;
    if (push) begin
      out_sym_r  <= held_r;
      out_last_r <= push_last;
    end
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[pop_data.index] <= mem_wdata;
    end
    rd_data_r <= mem_r[issue_r[htd_pkg::ADDR_W-1:0]];
  end

  assign out_chan.valid  = out_valid_r;
  assign out_chan.symbol = out_sym_r;
  assign out_chan.last   = out_last_r;

`ifndef SYNTHESIS
  a_idle_no_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !have_held_r)
    else $error("symbol still held while idle");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= htd_pkg::CNT_W'(htd_pkg::BUF_BITS))
    else $error("bit count beyond buffer size");

  a_res_limit: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= htd_pkg::RES_CNT_W'(htd_pkg::MAX_RESULTS))
    else $error("too many symbols for one byte");

  a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == ST_SCAN))
    else $error("table read in flight outside the scan");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> out_free)
    else $error("output register overwritten");
`endif

endmodule

// File: rtl/huffman_table_decoder_unit.sv
// Huffman table decoder top level: configuration registers, front end, queue, decode engine.
// A symbol is sent once the next search of its byte ends, so each one waits for the next hit
// or for the end of the byte; a new data byte is not taken before the last one is through.
// Each scan reads one table entry a cycle, up to the configured entry count.
// Input is taken while results wait, through a front stage and a two-entry queue.
// Reset (synchronous, rst_n low): buffer empty, first byte pending, registers zero;
// the code table is not cleared and holds garbage until loaded.
module huffman_table_decoder_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  htd_in_if.sink                           in_chan,
  htd_out_if.source                        out_chan,
  input  logic                             cfg_we,
  input  logic [htd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [htd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [htd_pkg::ENTRY_CNT_W-1:0] entry_count_r, entry_count_nxt;
  logic [htd_pkg::PAD_W-1:0]       pad_bits_r, pad_bits_nxt;

  logic              f_valid, f_ready;
  htd_pkg::q_entry_t f_data;
  logic              q_valid, q_ready;
  htd_pkg::q_entry_t q_data;

  // Configuration writes
  always_comb begin
    entry_count_nxt = entry_count_r;
    pad_bits_nxt    = pad_bits_r;
    if (cfg_we) begin
      unique case (cfg_index)
        htd_pkg::REG_ENTRY_COUNT: entry_count_nxt = cfg_data[htd_pkg::ENTRY_CNT_W-1:0];
        htd_pkg::REG_PAD_BITS:    pad_bits_nxt    = cfg_data[htd_pkg::PAD_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
      pad_bits_r    <= '0;
    end else begin
      entry_count_r <= entry_count_nxt;
      pad_bits_r    <= pad_bits_nxt;
    end
  end

  htd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data)
  );

  htd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  htd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop_valid   (q_valid),
    .pop_ready   (q_ready),
    .pop_data    (q_data),
    .entry_count (entry_count_r),
    .pad_bits    (pad_bits_r),
    .out_chan    (out_chan)
  );

endmodule
